>>> hdl/bsft_pkg.sv
// shared types, codes and default sizes for the binary semaphore table
`timescale 1ns / 1ps
package bsft_pkg;

  // default sizes
  localparam int NUM_SEMS_DEF    = 30;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int PID_BITS_DEF    = 16;

  // field widths
  localparam int OP_W     = 2;
  localparam int SEM_ID_W = 5;
  localparam int PROC_W   = 16;
  localparam int STATUS_W = 3;
  localparam int ACTION_W = 2;
  localparam int TARGET_W = 16;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // request codes
  localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
  localparam logic [OP_W-1:0] OP_TERM   = 2'd1;
  localparam logic [OP_W-1:0] OP_DOWN   = 2'd2;
  localparam logic [OP_W-1:0] OP_UP     = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ID     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXISTS     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_HOLDER = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_STOP = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CONT = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load;        // request register takes the incoming transaction
    logic meta_valid;  // semaphore record read data is valid
    logic head_valid;  // holder pid read data is valid
    logic commit;      // update state and load the result register
  } bsft_cmd_t;

endpackage

>>> hdl/binary_semaphore_fifo_table_unit.sv
// top level of the binary semaphore table with per semaphore fifo wait queues
`timescale 1ns / 1ps
// usage
// - slave stream carries requests: create, terminate, down or up on one
//   semaphore (ids 1 to NUM_SEMS) on behalf of one process id
// - master stream returns exactly one result transaction per request: a
//   status, an action to apply (stop or continue a process) and its pid
// - one request is in flight at a time; s_tready is high only while idle
// - an accepted request passes the record read and holder read states, then
//   the update loads the result register and raises m_tvalid when the register is empty or draining
// - pacing: each request runs through three chained ram reads
//   (semaphore record, holder pid, pid behind the holder) issued one per
//   cycle from the accept edge on, followed by the update cycle
// - the result register parts the two sides: a new request is taken while
//   a result is still waiting; a stalled receiver holds the next update in
//   its last cycle until the result register frees up
// - reset clears the exists and free flags of every semaphore at once; the
//   record and queue rams need no clearing pass since create initializes
//   the record and queue slots are only read after they were written
module binary_semaphore_fifo_table_unit
  import bsft_pkg::*;
#(
  parameter int NUM_SEMS    = NUM_SEMS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int PID_BITS    = PID_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // op[1:0], sem_id[6:2], proc_id[22:7], zero
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata   // status[2:0], action[4:3], target_pid[20:5], zero
);

  bsft_cmd_t cmd;

  // unpacked request fields
  logic [OP_W-1:0]     in_op;
  logic [SEM_ID_W-1:0] in_sem_id;
  logic [PROC_W-1:0]   in_proc_id;

  // result register contents
  logic [STATUS_W-1:0] status;
  logic [ACTION_W-1:0] action;
  logic [TARGET_W-1:0] target_pid;

  assign in_op      = s_tdata[OP_W-1:0];
  assign in_sem_id  = s_tdata[OP_W+SEM_ID_W-1:OP_W];
  assign in_proc_id = s_tdata[OP_W+SEM_ID_W+PROC_W-1:OP_W+SEM_ID_W];

  assign m_tdata = {(OUT_DATA_W - STATUS_W - ACTION_W - TARGET_W)'(0),
                    target_pid, action, status};

  // sequencer: idle, record read, holder read, update
  bsft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  // flags, record and queue rams, decision logic and result register
  bsft_datapath #(
    .NUM_SEMS    (NUM_SEMS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PID_BITS    (PID_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_op      (in_op),
    .in_sem_id  (in_sem_id),
    .in_proc_id (in_proc_id),
    .status     (status),
    .action     (action),
    .target_pid (target_pid)
  );

endmodule

>>> hdl/bsft_ram.sv
// generic single write port ram with a registered read port
`timescale 1ns / 1ps
module bsft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/bsft_ctrl.sv
// request sequencer and result handshake for the semaphore table
`timescale 1ns / 1ps
module bsft_ctrl
  import bsft_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output bsft_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_META = 2'd1;
  localparam logic [1:0] S_HEAD = 2'd2;
  localparam logic [1:0] S_EXEC = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       commit;

  assign in_ready = (state == S_IDLE);
  // result register must be empty or draining this cycle
  assign commit = (state == S_EXEC) && (!out_valid || out_ready);

  assign cmd.load       = in_valid && in_ready;
  assign cmd.meta_valid = (state == S_META);
  assign cmd.head_valid = (state == S_HEAD);
  assign cmd.commit     = commit;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_META;
        end
      end
      S_META: state_next = S_HEAD;
      S_HEAD: state_next = S_EXEC;
      S_EXEC: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/bsft_datapath.sv
// semaphore flags, queue records, pid queues and result register
`timescale 1ns / 1ps
module bsft_datapath
  import bsft_pkg::*;
#(
  parameter int NUM_SEMS    = NUM_SEMS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int PID_BITS    = PID_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  bsft_cmd_t           cmd,
  input  logic [OP_W-1:0]     in_op,
  input  logic [SEM_ID_W-1:0] in_sem_id,
  input  logic [PROC_W-1:0]   in_proc_id,
  output logic [STATUS_W-1:0] status,
  output logic [ACTION_W-1:0] action,
  output logic [TARGET_W-1:0] target_pid
);

  localparam int SEM_W   = NUM_SEMS > 1 ? $clog2(NUM_SEMS) : 1;
  localparam int HEAD_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W   = HEAD_W + 1;
  localparam int META_W  = HEAD_W + CNT_W;
  localparam int Q_TOTAL = NUM_SEMS * QUEUE_DEPTH;
  localparam int QADDR_W = Q_TOTAL > 1 ? $clog2(Q_TOTAL) : 1;
  localparam int IDX_W   = SEM_ID_W + 1;

  // request registers
  logic [OP_W-1:0]     req_op;
  logic [SEM_W-1:0]    req_idx;
  logic                req_ok;
  logic [PID_BITS-1:0] req_pid;
  logic [QADDR_W-1:0]  q_base;

  // per semaphore flags, cleared at reset
  logic [NUM_SEMS-1:0] sem_exists;
  logic [NUM_SEMS-1:0] sem_free;

  // record of the addressed semaphore
  logic [HEAD_W-1:0]   head_q;
  logic [CNT_W-1:0]    count_q;
  logic [PID_BITS-1:0] holder_pid;

  logic [SEM_W-1:0]    in_idx;
  logic                in_ok;
  logic [META_W-1:0]   meta_rdata;
  logic                meta_we;
  logic [META_W-1:0]   meta_wdata;
  logic [HEAD_W-1:0]   rd_head;
  logic [HEAD_W-1:0]   head_inc;
  logic [HEAD_W-1:0]   tail_slot;
  logic [QADDR_W-1:0]  q_raddr;
  logic [QADDR_W-1:0]  q_waddr;
  logic                q_we;
  logic [PID_BITS-1:0] q_rdata;
  logic                exists_s;
  logic                free_s;
  logic                set_exists;
  logic                clr_exists;
  logic                set_free;
  logic                clr_free;
  logic [STATUS_W-1:0] status_next;
  logic [ACTION_W-1:0] action_next;
  logic [PID_BITS-1:0] target_next;

  // slot arithmetic, the sum stays below twice the depth so one subtract wraps
  function automatic logic [HEAD_W-1:0] wrap_slot(input logic [HEAD_W-1:0] base,
                                                  input logic [CNT_W-1:0]  off);
    logic [SUM_W-1:0] sum;
    begin
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(QUEUE_DEPTH)) begin
        sum = sum - SUM_W'(QUEUE_DEPTH);
      end
      wrap_slot = HEAD_W'(sum);
    end
  endfunction

  assign in_idx = SEM_W'(IDX_W'(in_sem_id) - IDX_W'(1));
  assign in_ok  = (in_sem_id != '0) && (int'(in_sem_id) <= NUM_SEMS);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op  <= in_op;
      req_idx <= in_idx;
      req_ok  <= in_ok;
      req_pid <= PID_BITS'(in_proc_id);
      q_base  <= QADDR_W'(in_idx) * QADDR_W'(QUEUE_DEPTH);
    end
    if (cmd.meta_valid) begin
      head_q  <= meta_rdata[HEAD_W-1:0];
      count_q <= meta_rdata[META_W-1:HEAD_W];
    end
    if (cmd.head_valid) begin
      holder_pid <= q_rdata;
    end
  end

  // semaphore records: head slot and fill count
  bsft_ram #(
    .WIDTH (META_W),
    .DEPTH (NUM_SEMS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (req_idx),
    .wdata (meta_wdata),
    .raddr (in_idx),
    .rdata (meta_rdata)
  );

  // pid queues, one ring of QUEUE_DEPTH slots per semaphore
  assign rd_head   = meta_rdata[HEAD_W-1:0];
  assign head_inc  = wrap_slot(head_q, CNT_W'(1));
  assign tail_slot = wrap_slot(head_q, count_q);
  assign q_raddr   = q_base + QADDR_W'(cmd.meta_valid ? rd_head : head_inc);
  assign q_waddr   = q_base + QADDR_W'(tail_slot);

  bsft_ram #(
    .WIDTH (PID_BITS),
    .DEPTH (Q_TOTAL)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (req_pid),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  assign exists_s = req_ok ? sem_exists[req_idx] : 1'b0;
  assign free_s   = req_ok ? sem_free[req_idx] : 1'b0;

  always_comb begin
    status_next = ST_OK;
    action_next = ACT_NONE;
    target_next = '0;
    meta_we     = 1'b0;
    meta_wdata  = '0;
    q_we        = 1'b0;
    set_exists  = 1'b0;
    clr_exists  = 1'b0;
    set_free    = 1'b0;
    clr_free    = 1'b0;
    if (!req_ok) begin
      status_next = ST_BAD_ID;
    end else if (req_op == OP_CREATE) begin
      if (exists_s) begin
        status_next = ST_EXISTS;
      end else begin
        set_exists = 1'b1;
        set_free   = 1'b1;
        meta_we    = 1'b1;
      end
    end else if (!exists_s) begin
      status_next = ST_ABSENT;
    end else begin
      case (req_op)
        OP_TERM: begin
          clr_exists = 1'b1;
          clr_free   = 1'b1;
        end
        OP_DOWN: begin
          if (count_q >= CNT_W'(QUEUE_DEPTH)) begin
            status_next = ST_FULL;
          end else begin
            if (free_s) begin
              clr_free = 1'b1;
            end else begin
              action_next = ACT_STOP;
              target_next = req_pid;
            end
            q_we       = 1'b1;
            meta_we    = 1'b1;
            meta_wdata = {count_q + CNT_W'(1), head_q};
          end
        end
        OP_UP: begin
          if (free_s || count_q == '0 || holder_pid != req_pid) begin
            status_next = ST_NOT_HOLDER;
          end else begin
            meta_we    = 1'b1;
            meta_wdata = {count_q - CNT_W'(1), head_inc};
            if (count_q == CNT_W'(1)) begin
              set_free = 1'b1;
            end else begin
              action_next = ACT_CONT;
              target_next = q_rdata;
            end
          end
        end
        default: status_next = ST_OK;
      endcase
    end
    meta_we = meta_we && cmd.commit;
    q_we    = q_we && cmd.commit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sem_exists <= '0;
      sem_free   <= '0;
    end else if (cmd.commit) begin
      if (set_exists) begin
        sem_exists[req_idx] <= 1'b1;
      end else if (clr_exists) begin
        sem_exists[req_idx] <= 1'b0;
      end
      if (set_free) begin
        sem_free[req_idx] <= 1'b1;
      end else if (clr_free) begin
        sem_free[req_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status     <= status_next;
      action     <= action_next;
      target_pid <= TARGET_W'(target_next);
    end
  end

endmodule

>>> hdl/bsft_checker.sv
// port level checks for the semaphore table, bound to the top level
`timescale 1ns / 1ps
module bsft_checker
  import bsft_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // a stalled result stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  // one request in flight at a time
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in flight");

  // every accepted request is followed by a valid result
  a_result_due: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> ##4 m_tvalid)
    else $error("no result after an accepted request");

  // an action is ordered only on success
  a_action_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4:3] != ACT_NONE |-> m_tdata[2:0] == ST_OK)
    else $error("action ordered with a failing status");

  // no target without an action
  a_target_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4:3] == ACT_NONE |-> m_tdata[20:5] == '0)
    else $error("target pid set without an action");

endmodule

bind binary_semaphore_fifo_table_unit bsft_checker u_bsft_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
